>>> sv/bfw_pkg.sv
// Shared constants and types for the best-fitness window buffer.
package bfw_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int TAG_BITS_DEF = 16;
    localparam int FIT_W        = 32;
    localparam int PORT_TAG_W   = 16;
    localparam int LIMIT_W      = 5;
    localparam int OCC_W        = 5;
    localparam int WANT_W       = 8;
    localparam int IN_DATA_W    = 56;
    localparam int OUT_DATA_W   = 56;

    localparam logic [LIMIT_W-1:0] LIMIT_RST = 5'd16;

    // Input word kinds carried on tuser.
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_SELECT = 1'b1;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT,
        CELL_HEAD,
        CELL_LOAD
    } t_cell_sel;

    typedef struct packed {
        logic en;
        logic first;
    } t_scan_ctl;

endpackage

>>> sv/bfw_cell.sv
// One storage cell of the candidate chain: holds a tag and fitness pair.
module bfw_cell #(
    parameter int EW = 48
) (
    input  logic               i_clk,
    input  bfw_pkg::t_cell_sel i_sel,
    input  logic [EW-1:0]      i_right,
    input  logic [EW-1:0]      i_head,
    input  logic [EW-1:0]      i_new,
    output logic [EW-1:0]      o_entry
);
    import bfw_pkg::*;

    logic [EW-1:0] r_entry;
    logic [EW-1:0] n_entry;

    always_comb begin
        unique case (i_sel)
            CELL_HOLD:  n_entry = r_entry;
            CELL_SHIFT: n_entry = i_right;
            CELL_HEAD:  n_entry = i_head;
            CELL_LOAD:  n_entry = i_new;
            default:    n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

>>> sv/bfw_scan.sv
// Running maximum over entries presented one per cycle while enabled; the first maximum wins ties.
module bfw_scan #(
    parameter int EW = 48,
    parameter int IW = 4
) (
    input  logic               i_clk,
    input  bfw_pkg::t_scan_ctl i_ctl,
    input  logic [IW-1:0]      i_idx,
    input  logic [EW-1:0]      i_entry,
    output logic [IW-1:0]      o_best_idx,
    output logic [EW-1:0]      o_best_entry
);
    import bfw_pkg::*;

    logic [IW-1:0] r_best_idx;
    logic [EW-1:0] r_best_entry;
    logic          w_better;

    assign w_better = $signed(i_entry[FIT_W-1:0]) > $signed(r_best_entry[FIT_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en && (i_ctl.first || w_better)) begin
            r_best_idx   <= i_idx;
            r_best_entry <= i_entry;
        end
    end

    assign o_best_idx   = r_best_idx;
    assign o_best_entry = r_best_entry;

endmodule

>>> sv/best_fitness_window_buffer.sv
// Best-fitness window buffer: top level with chain of cells, scan unit and control.
//
// Candidates sit in a chain of cells in arrival order. An insert gives a single word,
// which is in the output register in the cycle after its accept. A select of n
// candidates from a buffer holding m entries gives n words; for each, the chain
// rotates one cell per cycle past the compare unit over the current occupancy, then
// the winner is removed and its word loaded, a step that waits for the output
// register to free. An empty select gives a single word. The block takes one input
// word at a time: a new word is accepted only when idle and only while the output
// register is empty or its word is taken in the same cycle, so after a select the
// next word waits at least until the last result is taken.
module best_fitness_window_buffer #(
    parameter int CAPACITY = bfw_pkg::CAPACITY_DEF,
    parameter int TAG_BITS = bfw_pkg::TAG_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wen,
    input  logic [bfw_pkg::LIMIT_W-1:0]       i_cfg_wdata,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // tdata: item_tag[15:0], item_fitness[47:16], select_count[55:48]
    input  logic [bfw_pkg::IN_DATA_W-1:0]     i_s_tdata,
    // tuser: kind
    input  logic                              i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // tdata: out_tag[15:0], out_fitness[47:16], dropped_oldest[48],
    // occupancy[53:49], zero fill[55:54]
    output logic [bfw_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    // tuser: found
    output logic                              o_m_tuser,
    output logic                              o_m_tlast
);
    import bfw_pkg::*;

    localparam int TW = (TAG_BITS < PORT_TAG_W) ? TAG_BITS : PORT_TAG_W;
    localparam int EW = TW + FIT_W;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int MW = ((CW > WANT_W) ? CW : WANT_W) + 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_TAKE = 2'd2;

    logic [1:0]            r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_left, n_left;
    logic [IW-1:0]         r_idx, n_idx;
    logic [LIMIT_W-1:0]    r_limit;
    logic                  r_ovalid, n_ovalid;
    logic                  r_ofound, n_ofound;
    logic [PORT_TAG_W-1:0] r_otag, n_otag;
    logic [FIT_W-1:0]      r_ofit, n_ofit;
    logic                  r_odrop, n_odrop;
    logic [OCC_W-1:0]      r_oocc, n_oocc;
    logic                  r_olast, n_olast;

    logic                  w_in_acc;
    logic                  w_out_free;
    logic [MW-1:0]         w_lim_eff;
    logic [MW-1:0]         w_cnt_ext;
    logic [MW-1:0]         w_want_ext;
    logic [MW-1:0]         w_sel_n;
    logic                  w_ins_drop;
    logic [CW-1:0]         w_cnt_m1;
    logic [EW-1:0]         w_new;
    logic [EW-1:0]         w_cells [CAPACITY];
    logic [EW-1:0]         w_right [CAPACITY];
    t_cell_sel             w_sel   [CAPACITY];
    t_scan_ctl             w_scan_ctl;
    logic [IW-1:0]         w_best_idx;
    logic [EW-1:0]         w_best_entry;

    assign w_out_free = !r_ovalid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE) && w_out_free;
    assign w_in_acc   = i_s_tvalid && o_s_tready;

    // Limit of zero acts as one, values past the capacity act as the capacity.
    always_comb begin
        w_lim_eff = MW'(r_limit);
        if (r_limit == '0) begin
            w_lim_eff = MW'(1);
        end else if (w_lim_eff > MW'(CAPACITY)) begin
            w_lim_eff = MW'(CAPACITY);
        end
    end

    assign w_cnt_ext  = MW'(r_count);
    assign w_cnt_m1   = r_count - CW'(1);
    assign w_ins_drop = (r_count == CW'(CAPACITY)) || ((w_cnt_ext + MW'(1)) > w_lim_eff);
    assign w_want_ext = MW'(i_s_tdata[55:48]);
    assign w_sel_n    = (w_want_ext < w_cnt_ext) ? w_want_ext : w_cnt_ext;
    assign w_new      = {i_s_tdata[TW-1:0], i_s_tdata[47:16]};

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            if (gi == CAPACITY - 1) begin : g_end
                assign w_right[gi] = '0;
            end else begin : g_mid
                assign w_right[gi] = w_cells[gi+1];
            end

            // An insert that drops the oldest appends and shifts in the same cycle.
            always_comb begin
                w_sel[gi] = CELL_HOLD;
                if (r_state == S_IDLE && w_in_acc && i_s_tuser == KIND_INSERT) begin
                    if (w_ins_drop) begin
                        if (CW'(gi) < w_cnt_m1) begin
                            w_sel[gi] = CELL_SHIFT;
                        end else if (CW'(gi) == w_cnt_m1) begin
                            w_sel[gi] = CELL_LOAD;
                        end
                    end else if (CW'(gi) == r_count) begin
                        w_sel[gi] = CELL_LOAD;
                    end
                end else if (r_state == S_SCAN) begin
                    if (CW'(gi) < w_cnt_m1) begin
                        w_sel[gi] = CELL_SHIFT;
                    end else if (CW'(gi) == w_cnt_m1) begin
                        w_sel[gi] = CELL_HEAD;
                    end
                end else if (r_state == S_TAKE && w_out_free && IW'(gi) >= w_best_idx) begin
                    w_sel[gi] = CELL_SHIFT;
                end
            end

            bfw_cell #(
                .EW(EW)
            ) u_cell (
                .i_clk   (i_clk),
                .i_sel   (w_sel[gi]),
                .i_right (w_right[gi]),
                .i_head  (w_cells[0]),
                .i_new   (w_new),
                .o_entry (w_cells[gi])
            );
        end
    endgenerate

    assign w_scan_ctl.en    = (r_state == S_SCAN);
    assign w_scan_ctl.first = (r_idx == '0);

    bfw_scan #(
        .EW(EW),
        .IW(IW)
    ) u_scan (
        .i_clk        (i_clk),
        .i_ctl        (w_scan_ctl),
        .i_idx        (r_idx),
        .i_entry      (w_cells[0]),
        .o_best_idx   (w_best_idx),
        .o_best_entry (w_best_entry)
    );

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_left   = r_left;
        n_idx    = r_idx;
        n_ovalid = r_ovalid && !i_m_tready;
        n_ofound = r_ofound;
        n_otag   = r_otag;
        n_ofit   = r_ofit;
        n_odrop  = r_odrop;
        n_oocc   = r_oocc;
        n_olast  = r_olast;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (i_s_tuser == KIND_INSERT) begin
                        n_count  = w_ins_drop ? r_count : (r_count + CW'(1));
                        n_ovalid = 1'b1;
                        n_ofound = 1'b0;
                        n_otag   = '0;
                        n_ofit   = '0;
                        n_odrop  = w_ins_drop;
                        n_oocc   = OCC_W'(n_count);
                        n_olast  = 1'b1;
                    end else if (w_sel_n == '0) begin
                        n_ovalid = 1'b1;
                        n_ofound = 1'b0;
                        n_otag   = '0;
                        n_ofit   = '0;
                        n_odrop  = 1'b0;
                        n_oocc   = OCC_W'(r_count);
                        n_olast  = 1'b1;
                    end else begin
                        n_left  = CW'(w_sel_n);
                        n_idx   = '0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_idx == IW'(w_cnt_m1)) begin
                    n_state = S_TAKE;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            S_TAKE: begin
                if (w_out_free) begin
                    n_count  = w_cnt_m1;
                    n_ovalid = 1'b1;
                    n_ofound = 1'b1;
                    n_otag   = PORT_TAG_W'(w_best_entry[EW-1:FIT_W]);
                    n_ofit   = w_best_entry[FIT_W-1:0];
                    n_odrop  = 1'b0;
                    n_oocc   = OCC_W'(w_cnt_m1);
                    n_olast  = (r_left == CW'(1));
                    if (r_left == CW'(1)) begin
                        n_state = S_IDLE;
                    end else begin
                        n_left  = r_left - CW'(1);
                        n_idx   = '0;
                        n_state = S_SCAN;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_left   <= '0;
            r_idx    <= '0;
            r_limit  <= LIMIT_RST;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_left   <= n_left;
            r_idx    <= n_idx;
            r_ovalid <= n_ovalid;
            if (i_cfg_wen) begin
                r_limit <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ofound <= n_ofound;
        r_otag   <= n_otag;
        r_ofit   <= n_ofit;
        r_odrop  <= n_odrop;
        r_oocc   <= n_oocc;
        r_olast  <= n_olast;
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tuser  = r_ofound;
    assign o_m_tlast  = r_olast;
    assign o_m_tdata  = {2'b00, r_oocc, r_odrop, r_ofit, r_otag};

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("occupancy above capacity");

    a_busy_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> r_count != '0)
        else $error("select in progress on an empty buffer");

    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && o_m_tvalid) |-> o_m_tlast)
        else $error("idle with a word that is not the last of its input");

    a_insert_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_s_tuser == KIND_INSERT) |=> (o_m_tvalid && o_m_tlast && !o_m_tuser))
        else $error("insert did not give its single word");

endmodule
